[rtl/assert_macros.svh]
// Concurrent assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[rtl/abpf_pkg.sv]
// Types, codes and masks shared by the alpha blend pipeline stages.
package abpf_pkg;

    // blend mode codes
    localparam logic [2:0] MODE_RGB888_SURF = 3'd0;
    localparam logic [2:0] MODE_ARGB_PIXEL  = 3'd1;
    localparam logic [2:0] MODE_565_SURF    = 3'd2;
    localparam logic [2:0] MODE_555_SURF    = 3'd3;
    localparam logic [2:0] MODE_ARGB_TO_565 = 3'd4;
    localparam logic [2:0] MODE_ARGB_TO_555 = 3'd5;

    // configuration register indexes
    localparam int          CFG_IDX_W         = 2;
    localparam logic [1:0]  CFG_BLEND_MODE    = 2'd0;
    localparam logic [1:0]  CFG_SURFACE_ALPHA = 2'd1;

    // lane masks
    localparam logic [31:0] RB_LANE    = 32'h00ff00ff;
    localparam logic [31:0] G_LANE     = 32'h0000ff00;
    localparam logic [31:0] SPREAD565  = 32'h07e0f81f;
    localparam logic [31:0] SPREAD555  = 32'h03e07c1f;

    // how the last stage forms the result
    typedef enum logic [1:0] {
        KIND_LANE8  = 2'd0,
        KIND_LANE5  = 2'd1,
        KIND_BYPASS = 2'd2
    } t_kind;

    // decode stage to multiply stage
    typedef struct packed {
        t_kind       kind;
        logic        sel555;
        logic [31:0] diff_a;
        logic [31:0] diff_b;
        logic [31:0] dst_a;
        logic [31:0] dst_b;
        logic [7:0]  alpha;
        logic [7:0]  hi_byte;
        logic [31:0] bypass;
    } t_dec;

    // multiply stage to merge stage
    typedef struct packed {
        t_kind       kind;
        logic        sel555;
        logic [31:0] prod_a;
        logic [31:0] prod_b;
        logic [31:0] dst_a;
        logic [31:0] dst_b;
        logic [7:0]  hi_byte;
        logic [31:0] bypass;
    } t_mul;

    // spread a 16-bit pixel into G0RB form
    function automatic logic [31:0] spread(input logic [15:0] p, input logic [31:0] mask);
        spread = {p, p} & mask;
    endfunction

endpackage

[rtl/alpha_blend_pixel_formats_unit.sv]
// Top level of the pixel alpha blender: configuration registers and three-stage pipeline.
//
// Blends one source pixel over one destination pixel per clock in one of six
// format pairs chosen by blend_mode (config index 0; surface_alpha is index 1).
// A beat is taken on every clock where start is high; busy never rises, so a
// new pixel may follow in the next cycle. Each pixel gives exactly one result,
// shown on o_blended_pixel with o_result_valid for one cycle, after it has
// passed the decode, multiply and merge registers, one register stage each,
// the 32x8 lane multipliers setting the middle one. The receiver cannot stall
// the output, so results must be taken when the strobe is high. Write the
// configuration only while no pixel is in flight; writes to unused indexes are
// dropped.
`include "assert_macros.svh"

module alpha_blend_pixel_formats_unit
    import abpf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [31:0]          i_source_pixel,
    input  logic [31:0]          i_dest_pixel,
    output logic                 o_result_valid,
    output logic [31:0]          o_blended_pixel,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    logic [2:0] r_blend_mode;
    logic [7:0] r_surface_alpha;
    logic       accept;
    logic       dec_valid;
    t_dec       dec;
    logic       mul_valid;
    t_mul       mul;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // write configuration registers, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode    <= MODE_RGB888_SURF;
            r_surface_alpha <= 8'hff;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BLEND_MODE:    r_blend_mode    <= i_cfg_data[2:0];
                CFG_SURFACE_ALPHA: r_surface_alpha <= i_cfg_data;
                default: begin
                    r_blend_mode <= r_blend_mode;
                end
            endcase
        end
    end

    abpf_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_src        (i_source_pixel),
        .i_dst        (i_dest_pixel),
        .i_mode       (r_blend_mode),
        .i_surf_alpha (r_surface_alpha),
        .o_valid      (dec_valid),
        .o_dec        (dec)
    );

    abpf_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .i_dec   (dec),
        .o_valid (mul_valid),
        .o_mul   (mul)
    );

    abpf_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .i_mul   (mul),
        .o_valid (o_result_valid),
        .o_pixel (o_blended_pixel)
    );

    // every taken beat gives a result
    `ASSERT_CLK(a_beat_out, i_clk, i_rst_n, accept |-> ##3 o_result_valid, "taken beat lost")
    // no result without a matching taken beat
    `ASSERT_CLK(a_no_extra, i_clk, i_rst_n,
        o_result_valid |-> $past(accept, 3), "result without beat")
    // RGB888 surface blend always sets the top byte
    `ASSERT_CLK(a_rgb888_top, i_clk, i_rst_n,
        (o_result_valid && ($past(r_blend_mode, 3) == MODE_RGB888_SURF))
            |-> (o_blended_pixel[31:24] == 8'hff),
        "rgb888 top byte not set")
    // 16-bit destination formats are zero-extended
    `ASSERT_CLK(a_16bit_zext, i_clk, i_rst_n,
        (o_result_valid && ($past(r_blend_mode, 3) == MODE_565_SURF
                            || $past(r_blend_mode, 3) == MODE_555_SURF
                            || $past(r_blend_mode, 3) == MODE_ARGB_TO_565
                            || $past(r_blend_mode, 3) == MODE_ARGB_TO_555))
            |-> (o_blended_pixel[31:16] == 16'h0000),
        "16-bit result not zero-extended")

endmodule

[rtl/abpf_decode.sv]
// First stage: pick alpha, lane operands and differences per blend mode.
module abpf_decode
    import abpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_src,
    input  logic [31:0] i_dst,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_surf_alpha,
    output logic        o_valid,
    output t_dec        o_dec
);

    logic        r_valid;
    t_dec        r_dec;
    t_dec        n_dec;
    logic [31:0] sa;
    logic [31:0] da;
    logic [31:0] sb;
    logic [31:0] db;

    // decode operands for the selected format pair
    always_comb begin
        sa            = '0;
        da            = '0;
        sb            = '0;
        db            = '0;
        n_dec.kind    = KIND_BYPASS;
        n_dec.sel555  = 1'b0;
        n_dec.alpha   = '0;
        n_dec.hi_byte = '0;
        n_dec.bypass  = i_dst;
        case (i_mode)
            MODE_RGB888_SURF: begin
                n_dec.kind    = KIND_LANE8;
                n_dec.alpha   = i_surf_alpha;
                n_dec.hi_byte = 8'hff;
                sa = i_src & RB_LANE;
                da = i_dst & RB_LANE;
                sb = i_src & G_LANE;
                db = i_dst & G_LANE;
            end
            MODE_ARGB_PIXEL: begin
                n_dec.alpha   = i_src[31:24];
                n_dec.hi_byte = i_dst[31:24];
                n_dec.bypass  = {i_dst[31:24], i_src[23:0]};
                n_dec.kind    = (i_src[31:24] == 8'hff) ? KIND_BYPASS : KIND_LANE8;
                sa = i_src & RB_LANE;
                da = i_dst & RB_LANE;
                sb = i_src & G_LANE;
                db = i_dst & G_LANE;
            end
            MODE_565_SURF: begin
                n_dec.kind  = KIND_LANE5;
                n_dec.alpha = {3'b000, i_surf_alpha[7:3]};
                sa = spread(i_src[15:0], SPREAD565);
                da = spread(i_dst[15:0], SPREAD565);
            end
            MODE_555_SURF: begin
                n_dec.kind   = KIND_LANE5;
                n_dec.sel555 = 1'b1;
                n_dec.alpha  = {3'b000, i_surf_alpha[7:3]};
                sa = spread(i_src[15:0], SPREAD555);
                da = spread(i_dst[15:0], SPREAD555);
            end
            MODE_ARGB_TO_565: begin
                n_dec.alpha  = {3'b000, i_src[31:27]};
                n_dec.bypass = {16'h0000, i_src[23:19], i_src[15:10], i_src[7:3]};
                n_dec.kind   = (i_src[31:27] == 5'h1f) ? KIND_BYPASS : KIND_LANE5;
                sa = {5'b0, i_src[15:10], 5'b0, i_src[23:19], 6'b0, i_src[7:3]};
                da = spread(i_dst[15:0], SPREAD565);
            end
            MODE_ARGB_TO_555: begin
                n_dec.sel555 = 1'b1;
                n_dec.alpha  = {3'b000, i_src[31:27]};
                n_dec.bypass = {17'h00000, i_src[23:19], i_src[15:11], i_src[7:3]};
                n_dec.kind   = (i_src[31:27] == 5'h1f) ? KIND_BYPASS : KIND_LANE5;
                sa = {6'b0, i_src[15:11], 6'b0, i_src[23:19], 5'b0, i_src[7:3]};
                da = spread(i_dst[15:0], SPREAD555);
            end
            default: begin
                n_dec.kind   = KIND_BYPASS;
                n_dec.bypass = i_dst;
            end
        endcase
        n_dec.diff_a = sa - da;
        n_dec.diff_b = sb - db;
        n_dec.dst_a  = da;
        n_dec.dst_b  = db;
    end

    // advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // capture the beat
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

[rtl/abpf_mult.sv]
// Second stage: scale both lane differences by alpha, modulo 2^32.
module abpf_mult
    import abpf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_dec i_dec,
    output logic o_valid,
    output t_mul o_mul
);

    logic r_valid;
    t_mul r_mul;
    t_mul n_mul;

    // multiply the lanes, keep the low word
    always_comb begin
        n_mul.kind    = i_dec.kind;
        n_mul.sel555  = i_dec.sel555;
        n_mul.prod_a  = 32'(i_dec.diff_a * {24'h000000, i_dec.alpha});
        n_mul.prod_b  = 32'(i_dec.diff_b * {24'h000000, i_dec.alpha});
        n_mul.dst_a   = i_dec.dst_a;
        n_mul.dst_b   = i_dec.dst_b;
        n_mul.hi_byte = i_dec.hi_byte;
        n_mul.bypass  = i_dec.bypass;
    end

    // advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // capture the beat
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_mul <= n_mul;
        end
    end

    assign o_valid = r_valid;
    assign o_mul   = r_mul;

endmodule

[rtl/abpf_merge.sv]
// Third stage: shift, add back the destination, mask and pack the result pixel, or pass the bypass pixel.
module abpf_merge
    import abpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_mul        i_mul,
    output logic        o_valid,
    output logic [31:0] o_pixel
);

    logic        r_valid;
    logic [31:0] r_pixel;
    logic [31:0] n_pixel;
    logic [31:0] sum8_a;
    logic [31:0] sum8_b;
    logic [31:0] sum5;

    // form the blended pixel for each result kind
    always_comb begin
        sum8_a = (i_mul.dst_a + (i_mul.prod_a >> 8)) & RB_LANE;
        sum8_b = (i_mul.dst_b + (i_mul.prod_b >> 8)) & G_LANE;
        sum5   = (i_mul.dst_a + (i_mul.prod_a >> 5))
               & (i_mul.sel555 ? SPREAD555 : SPREAD565);
        case (i_mul.kind)
            KIND_LANE8:  n_pixel = sum8_a | sum8_b | {i_mul.hi_byte, 24'h000000};
            KIND_LANE5:  n_pixel = {16'h0000, sum5[15:0] | sum5[31:16]};
            KIND_BYPASS: n_pixel = i_mul.bypass;
            default:     n_pixel = i_mul.bypass;
        endcase
    end

    // advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // capture the beat
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

endmodule
